[hdl/ckag_pkg.sv]
`timescale 1ns / 1ps

package ckag_pkg;

	// pixel and key component width
	localparam int CHAN_W = 8;

	// configuration port
	localparam int CFG_REGS  = 4;
	localparam int CFG_IDX_W = $clog2(CFG_REGS);
	localparam int CFG_DAT_W = CHAN_W;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_RED   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_GREEN = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_BLUE  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SOFT_MODE = CFG_IDX_W'(3);

	// alpha scale: alpha = floor(255 * sqrt(d2) / 260)
	// 67600*a*a <= 65025*d2 reduces to 2704*a*a <= 2601*d2 (both sides over 25)
	localparam int ALPHA_MAX  = 255;
	localparam int DIST_LIM2  = 260 * 260;
	localparam int KEY_SCALE  = (ALPHA_MAX * ALPHA_MAX) / 25;
	localparam int LIM_SCALE  = DIST_LIM2 / 25;

	// internal widths
	localparam int SQ_W   = 2 * CHAN_W;
	localparam int D2_W   = SQ_W + 2;
	localparam int REM_W  = 29;
	localparam int T_W    = 20;
	localparam int ROOT_W = CHAN_W;

	// pipeline depth: diff, square, sum, scale, eight root steps, output
	localparam int ROOT_FIRST = 5;
	localparam int NUM_STAGES = ROOT_FIRST + ROOT_W;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              match;
		logic              over;
	} item_meta_t;

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

[hdl/chroma_key_alpha_generator.sv]
`timescale 1ns / 1ps
// path from input accept to out_valid: the distance stages,
// an eight-step restoring square root (one result bit per stage) and an output register
// throughput: one item per cycle; a stalled output holds its stage and bubbles collapse
// reset: arst_n clears all valid bits, the key color and soft_mode to zero

module chroma_key_alpha_generator
	import ckag_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	// pixel input
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CHAN_W-1:0]    blue_in,
	input  logic [CHAN_W-1:0]    green_in,
	input  logic [CHAN_W-1:0]    red_in,
	// pixel output
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CHAN_W-1:0]    red_out,
	output logic [CHAN_W-1:0]    green_out,
	output logic [CHAN_W-1:0]    blue_out,
	output logic [CHAN_W-1:0]    alpha_out
);

	// configuration registers
	logic [CHAN_W-1:0] key_red_q;
	logic [CHAN_W-1:0] key_green_q;
	logic [CHAN_W-1:0] key_blue_q;
	logic              soft_mode_q;

	// pipeline control
	logic [1:NUM_STAGES]   vld_s;
	logic [1:NUM_STAGES]   vld_prev;
	logic [1:NUM_STAGES+1] ce;

	// pipeline payload
	item_meta_t        meta_s [1:NUM_STAGES];
	logic [CHAN_W-1:0] dr_s1, dg_s1, db_s1;
	logic [SQ_W-1:0]   sqr_s2, sqg_s2, sqb_s2;
	logic [D2_W-1:0]   d2_s3;
	logic              over_val;
	logic [REM_W-1:0]  rem_s  [ROOT_FIRST-1:NUM_STAGES-1];
	logic [T_W-1:0]    t_s    [ROOT_FIRST-1:NUM_STAGES-1];
	logic [ROOT_W-1:0] root_s [ROOT_FIRST-1:NUM_STAGES-1];
	logic [REM_W-1:0]  trial  [ROOT_FIRST:NUM_STAGES-1];
	logic              fits   [ROOT_FIRST:NUM_STAGES-1];
	logic [CHAN_W-1:0] alpha_s13;
	logic [CHAN_W-1:0] alpha_val;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_red_q   <= '0;
			key_green_q <= '0;
			key_blue_q  <= '0;
			soft_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_RED:   key_red_q   <= cfg_data[CHAN_W-1:0];
				REG_KEY_GREEN: key_green_q <= cfg_data[CHAN_W-1:0];
				REG_KEY_BLUE:  key_blue_q  <= cfg_data[CHAN_W-1:0];
				REG_SOFT_MODE: soft_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// per-stage advance: a stage moves when empty or when the next one moves
	assign ce[NUM_STAGES+1] = out_ready;
	for (genvar i = 1; i <= NUM_STAGES; i++) begin : g_ce
		assign ce[i] = !vld_s[i] || ce[i+1];
	end
	assign vld_prev = {in_valid, vld_s[1:NUM_STAGES-1]};
	assign in_ready = ce[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = 1; i <= NUM_STAGES; i++) begin
				if (ce[i]) begin
					vld_s[i] <= vld_prev[i];
				end
			end
		end
	end

	// item color and flags travel with the item
	assign over_val = d2_s3 > D2_W'(DIST_LIM2);

	always_ff @(posedge clk) begin
		if (ce[1]) begin
			meta_s[1] <= '{red: red_in, green: green_in, blue: blue_in,
				match: (red_in == key_red_q) && (green_in == key_green_q) &&
					(blue_in == key_blue_q),
				over: 1'b0};
		end
		for (int i = 2; i <= NUM_STAGES; i++) begin
			if (ce[i]) begin
				if (i == ROOT_FIRST - 1) begin
					meta_s[i] <= '{red: meta_s[i-1].red, green: meta_s[i-1].green,
						blue: meta_s[i-1].blue, match: meta_s[i-1].match,
						over: over_val};
				end else begin
					meta_s[i] <= meta_s[i-1];
				end
			end
		end
	end

	// stage 1: component distances
	always_ff @(posedge clk) begin
		if (ce[1]) begin
			dr_s1 <= abs_diff(red_in, key_red_q);
			dg_s1 <= abs_diff(green_in, key_green_q);
			db_s1 <= abs_diff(blue_in, key_blue_q);
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (ce[2]) begin
			sqr_s2 <= SQ_W'(dr_s1) * SQ_W'(dr_s1);
			sqg_s2 <= SQ_W'(dg_s1) * SQ_W'(dg_s1);
			sqb_s2 <= SQ_W'(db_s1) * SQ_W'(db_s1);
		end
	end

	// stage 3: squared distance
	always_ff @(posedge clk) begin
		if (ce[3]) begin
			d2_s3 <= D2_W'(sqr_s2) + D2_W'(sqg_s2) + D2_W'(sqb_s2);
		end
	end

	// stage 4: scaled distance, root starts from zero
	always_ff @(posedge clk) begin
		if (ce[ROOT_FIRST-1]) begin
			rem_s[ROOT_FIRST-1]  <= REM_W'(d2_s3) * REM_W'(KEY_SCALE);
			t_s[ROOT_FIRST-1]    <= '0;
			root_s[ROOT_FIRST-1] <= '0;
		end
	end

	// root steps: keep rem = N - 2704*a*a and t = 2704*a, try one bit per stage
	always_comb begin
		for (int st = ROOT_FIRST; st < NUM_STAGES; st++) begin
			trial[st] = (REM_W'({t_s[st-1], 1'b0}) +
				(REM_W'(LIM_SCALE) << (NUM_STAGES - 1 - st))) << (NUM_STAGES - 1 - st);
			fits[st]  = trial[st] <= rem_s[st-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int st = ROOT_FIRST; st < NUM_STAGES; st++) begin
			if (ce[st]) begin
				if (fits[st]) begin
					rem_s[st]  <= rem_s[st-1] - trial[st];
					t_s[st]    <= t_s[st-1] + (T_W'(LIM_SCALE) << (NUM_STAGES - 1 - st));
					root_s[st] <= root_s[st-1] | (ROOT_W'(1) << (NUM_STAGES - 1 - st));
				end else begin
					rem_s[st]  <= rem_s[st-1];
					t_s[st]    <= t_s[st-1];
					root_s[st] <= root_s[st-1];
				end
			end
		end
	end

	// output stage: alpha select
	always_comb begin
		if (!soft_mode_q) begin
			alpha_val = meta_s[NUM_STAGES-1].match ? '0 : CHAN_W'(ALPHA_MAX);
		end else if (meta_s[NUM_STAGES-1].over) begin
			alpha_val = CHAN_W'(ALPHA_MAX);
		end else begin
			alpha_val = root_s[NUM_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce[NUM_STAGES]) begin
			alpha_s13 <= alpha_val;
		end
	end

	assign out_valid = vld_s[NUM_STAGES];
	assign red_out   = meta_s[NUM_STAGES].red;
	assign green_out = meta_s[NUM_STAGES].green;
	assign blue_out  = meta_s[NUM_STAGES].blue;
	assign alpha_out = alpha_s13;

	// checks
	a_hard_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !soft_mode_q |->
			(alpha_out == '0) == ((red_out == key_red_q) && (green_out == key_green_q) &&
				(blue_out == key_blue_q)))
		else $error("hard mode alpha does not follow key match");

	a_hard_levels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !soft_mode_q |-> alpha_out == '0 || alpha_out == CHAN_W'(ALPHA_MAX))
		else $error("hard mode alpha neither transparent nor opaque");

	a_soft_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && soft_mode_q && (red_out == key_red_q) && (green_out == key_green_q) &&
			(blue_out == key_blue_q) |-> alpha_out == '0)
		else $error("soft mode key pixel not transparent");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s[1] && !out_ready && out_valid)
		else $error("input stalled while pipeline can move");

endmodule
